// ===== sv/jdm_pkg.sv =====
// joystick drive mixer: types, codes and the level scaling function shared by the
// stages of the mixer pipeline; depends on nothing

package jdm_pkg;

    localparam int AXIS_W    = 12;
    localparam int LEVEL_W   = 10;
    localparam int DIST_W    = 12;
    localparam int FRAC_BITS = 10;
    localparam int LEVEL_MAX = 1023;
    localparam int SQ_W      = 2 * AXIS_W;
    localparam int ROOT_W    = AXIS_W;
    localparam int REM_W     = ROOT_W + 3;

    localparam logic [DIST_W-1:0] MIN_DIST_RESET = DIST_W'(100);

    localparam logic [1:0] CMD_DISCONNECT = 2'd2;
    localparam logic [1:0] CMD_SET_LEVELS = 2'd3;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BACK = 2'd2
    } dir_t;

    // where a motor's level comes from
    typedef enum logic [1:0] {
        SRC_ZERO = 2'd0,
        SRC_X    = 2'd1,
        SRC_Y    = 2'd2,
        SRC_MAG  = 2'd3
    } lvl_src_t;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [AXIS_W-1:0] factor_x;
        logic signed [AXIS_W-1:0] factor_y;
        logic [DIST_W-1:0]        obstacle_mm;
    } drive_cmd_t;

    typedef struct packed {
        dir_t               motor_a_dir;
        dir_t               motor_b_dir;
        logic [LEVEL_W-1:0] level_a;
        logic [LEVEL_W-1:0] level_b;
        logic               blocked;
    } drive_res_t;

    typedef struct packed {
        dir_t     da;
        dir_t     db;
        lvl_src_t src_a;
        lvl_src_t src_b;
        logic     blocked;
    } mix_ctl_t;

    typedef struct packed {
        mix_ctl_t           ctl;
        logic [LEVEL_W-1:0] lvl_x;
        logic [LEVEL_W-1:0] lvl_y;
    } mix_side_t;

    // floor(m * LEVEL_MAX / 2^FRAC_BITS), saturated at LEVEL_MAX
    function automatic logic [LEVEL_W-1:0] scale_level(input logic [AXIS_W-1:0] m);
        logic [AXIS_W+LEVEL_W-1:0] prod;
        logic [AXIS_W+LEVEL_W-1:0] v;
        prod = {{LEVEL_W{1'b0}}, m} * (AXIS_W + LEVEL_W)'(LEVEL_MAX);
        v    = prod >> FRAC_BITS;
        if (v > (AXIS_W + LEVEL_W)'(LEVEL_MAX))
            return LEVEL_W'(LEVEL_MAX);
        else
            return v[LEVEL_W-1:0];
    endfunction

endpackage

// ===== sv/joystick_drive_mixer_unit.sv =====
// joystick drive mixer top level: threshold register and the six-stage mixer pipeline
// depends on jdm_pkg, jdm_decode, jdm_square, jdm_sqrt_stage, jdm_mix

// Takes one command per clock: busy never rises. A disconnect or set-levels
// command gives its result, marked by done for one cycle; other command codes
// give nothing. The result passes through the six registers of the pipeline,
// the first of which captures the transfer: decode, sum of squares, three
// square-root stages of four root bits each, and the final scale and select.
// The receiver cannot stall, so results leave at the rate commands arrive.
// Write the distance threshold only while no command is in flight.

module joystick_drive_mixer_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  jdm_pkg::drive_cmd_t        cmd,
    output logic                       done,
    output jdm_pkg::drive_res_t        result,
    input  logic                       wr_en,
    input  logic [jdm_pkg::DIST_W-1:0] wr_data
);
    import jdm_pkg::*;

    localparam int SQRT_STAGES = 3;
    localparam int SQRT_DIGITS = ROOT_W / SQRT_STAGES;

    logic [DIST_W-1:0] min_dist_reg;

    logic              dec_valid;
    mix_ctl_t          dec_ctl;
    logic [AXIS_W-1:0] dec_ax;
    logic [AXIS_W-1:0] dec_ay;

    logic              sq_valid;
    mix_side_t         sq_side;
    logic [SQ_W-1:0]   sq_sum;

    logic              rt_valid [SQRT_STAGES+1];
    mix_side_t         rt_side  [SQRT_STAGES+1];
    logic [SQ_W-1:0]   rt_rad   [SQRT_STAGES+1];
    logic [REM_W-1:0]  rt_rem   [SQRT_STAGES+1];
    logic [ROOT_W-1:0] rt_root  [SQRT_STAGES+1];

    // no stage ever waits
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_dist_reg <= MIN_DIST_RESET;
        else if (wr_en)
            min_dist_reg <= wr_data;
    end

    jdm_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (start && !busy),
        .cmd      (cmd),
        .min_dist (min_dist_reg),
        .valid    (dec_valid),
        .ctl      (dec_ctl),
        .ax       (dec_ax),
        .ay       (dec_ay)
    );

    jdm_square u_square (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (dec_valid),
        .ctl      (dec_ctl),
        .ax       (dec_ax),
        .ay       (dec_ay),
        .valid    (sq_valid),
        .side     (sq_side),
        .sum_sq   (sq_sum)
    );

    assign rt_valid[0] = sq_valid;
    assign rt_side[0]  = sq_side;
    assign rt_rad[0]   = sq_sum;
    assign rt_rem[0]   = '0;
    assign rt_root[0]  = '0;

    for (genvar s = 0; s < SQRT_STAGES; s++)
    begin : g_sqrt
        jdm_sqrt_stage #(
            .FIRST_DIGIT (ROOT_W - 1 - s * SQRT_DIGITS),
            .DIGITS      (SQRT_DIGITS)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (rt_valid[s]),
            .in_side  (rt_side[s]),
            .in_rad   (rt_rad[s]),
            .in_rem   (rt_rem[s]),
            .in_root  (rt_root[s]),
            .valid    (rt_valid[s+1]),
            .side     (rt_side[s+1]),
            .rad      (rt_rad[s+1]),
            .rem      (rt_rem[s+1]),
            .root     (rt_root[s+1])
        );
    end

    jdm_mix u_mix (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rt_valid[SQRT_STAGES]),
        .side     (rt_side[SQRT_STAGES]),
        .mag      (rt_root[SQRT_STAGES]),
        .done     (done),
        .result   (result)
    );

endmodule

// ===== sv/jdm_decode.sv =====
// joystick drive mixer, first stage: region decode, anticollision check, axis magnitudes
// depends on jdm_pkg

module jdm_decode (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       take,
    input  jdm_pkg::drive_cmd_t        cmd,
    input  logic [jdm_pkg::DIST_W-1:0] min_dist,
    output logic                       valid,
    output jdm_pkg::mix_ctl_t          ctl,
    output logic [jdm_pkg::AXIS_W-1:0] ax,
    output logic [jdm_pkg::AXIS_W-1:0] ay
);
    import jdm_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    mix_ctl_t          ctl_reg;
    mix_ctl_t          ctl_next;
    logic [AXIS_W-1:0] ax_reg;
    logic [AXIS_W-1:0] ax_next;
    logic [AXIS_W-1:0] ay_reg;
    logic [AXIS_W-1:0] ay_next;
    logic              x_zero;
    logic              y_zero;
    logic              x_pos;
    logic              y_pos;
    logic              fwd;

    assign x_zero = (cmd.factor_x == '0);
    assign y_zero = (cmd.factor_y == '0);
    assign x_pos  = !cmd.factor_x[AXIS_W-1] && !x_zero;
    assign y_pos  = !cmd.factor_y[AXIS_W-1] && !y_zero;

    // the most negative code has magnitude 2^(AXIS_W-1), still fits unsigned
    assign ax_next = cmd.factor_x[AXIS_W-1] ? AXIS_W'(-cmd.factor_x) : cmd.factor_x;
    assign ay_next = cmd.factor_y[AXIS_W-1] ? AXIS_W'(-cmd.factor_y) : cmd.factor_y;

    assign valid_next = take &&
        (cmd.req_type == CMD_DISCONNECT || cmd.req_type == CMD_SET_LEVELS);

    always_comb
    begin
        ctl_next.da      = DIR_STOP;
        ctl_next.db      = DIR_STOP;
        ctl_next.src_a   = SRC_ZERO;
        ctl_next.src_b   = SRC_ZERO;
        ctl_next.blocked = 1'b0;
        fwd              = 1'b0;
        if (cmd.req_type == CMD_SET_LEVELS)
        begin
            if (x_zero && y_zero)
            begin
                fwd = 1'b0;
            end
            else if (y_pos || y_zero)
            begin
                fwd = 1'b1;
                if (y_zero && x_pos)
                begin
                    ctl_next.da    = DIR_FWD;
                    ctl_next.src_a = SRC_X;
                end
                else if (y_zero)
                begin
                    ctl_next.db    = DIR_FWD;
                    ctl_next.src_b = SRC_X;
                end
                else
                begin
                    ctl_next.da = DIR_FWD;
                    ctl_next.db = DIR_FWD;
                    if (x_pos)
                    begin
                        ctl_next.src_a = SRC_MAG;
                        ctl_next.src_b = SRC_Y;
                    end
                    else if (x_zero)
                    begin
                        ctl_next.src_a = SRC_Y;
                        ctl_next.src_b = SRC_Y;
                    end
                    else
                    begin
                        ctl_next.src_a = SRC_Y;
                        ctl_next.src_b = SRC_MAG;
                    end
                end
            end
            else
            begin
                ctl_next.da = DIR_BACK;
                ctl_next.db = DIR_BACK;
                if (x_pos)
                begin
                    ctl_next.src_a = SRC_MAG;
                    ctl_next.src_b = SRC_Y;
                end
                else if (x_zero)
                begin
                    ctl_next.src_a = SRC_Y;
                    ctl_next.src_b = SRC_Y;
                end
                else
                begin
                    ctl_next.src_a = SRC_Y;
                    ctl_next.src_b = SRC_MAG;
                end
            end
            // forward motion needs the obstacle strictly beyond the threshold
            if (fwd && !(cmd.obstacle_mm > min_dist))
            begin
                ctl_next.da      = DIR_STOP;
                ctl_next.db      = DIR_STOP;
                ctl_next.src_a   = SRC_ZERO;
                ctl_next.src_b   = SRC_ZERO;
                ctl_next.blocked = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        ctl_reg <= ctl_next;
        ax_reg  <= ax_next;
        ay_reg  <= ay_next;
    end

    assign valid = valid_reg;
    assign ctl   = ctl_reg;
    assign ax    = ax_reg;
    assign ay    = ay_reg;

endmodule

// ===== sv/jdm_square.sv =====
// joystick drive mixer, second stage: sum of squares and scaled axis levels
// depends on jdm_pkg

module jdm_square (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  jdm_pkg::mix_ctl_t          ctl,
    input  logic [jdm_pkg::AXIS_W-1:0] ax,
    input  logic [jdm_pkg::AXIS_W-1:0] ay,
    output logic                       valid,
    output jdm_pkg::mix_side_t         side,
    output logic [jdm_pkg::SQ_W-1:0]   sum_sq
);
    import jdm_pkg::*;

    logic            valid_reg;
    mix_side_t       side_reg;
    mix_side_t       side_next;
    logic [SQ_W-1:0] sum_reg;
    logic [SQ_W-1:0] sum_next;
    logic [SQ_W-1:0] sq_x;
    logic [SQ_W-1:0] sq_y;

    assign sq_x     = SQ_W'(ax) * SQ_W'(ax);
    assign sq_y     = SQ_W'(ay) * SQ_W'(ay);
    // both squares are at most 2^(SQ_W-2), so the sum cannot carry out
    assign sum_next = sq_x + sq_y;

    always_comb
    begin
        side_next.ctl   = ctl;
        side_next.lvl_x = scale_level(ax);
        side_next.lvl_y = scale_level(ay);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        side_reg <= side_next;
        sum_reg  <= sum_next;
    end

    assign valid  = valid_reg;
    assign side   = side_reg;
    assign sum_sq = sum_reg;

endmodule

// ===== sv/jdm_sqrt_stage.sv =====
// joystick drive mixer: one registered slice of the restoring square root,
// resolving DIGITS root bits per stage; depends on jdm_pkg

module jdm_sqrt_stage #(
    parameter int FIRST_DIGIT = 11,
    parameter int DIGITS      = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  jdm_pkg::mix_side_t         in_side,
    input  logic [jdm_pkg::SQ_W-1:0]   in_rad,
    input  logic [jdm_pkg::REM_W-1:0]  in_rem,
    input  logic [jdm_pkg::ROOT_W-1:0] in_root,
    output logic                       valid,
    output jdm_pkg::mix_side_t         side,
    output logic [jdm_pkg::SQ_W-1:0]   rad,
    output logic [jdm_pkg::REM_W-1:0]  rem,
    output logic [jdm_pkg::ROOT_W-1:0] root
);
    import jdm_pkg::*;

    logic              valid_reg;
    mix_side_t         side_reg;
    logic [SQ_W-1:0]   rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W-1:0] root_next;

    always_comb
    begin
        logic [REM_W-1:0] r;
        logic [REM_W-1:0] trial;
        logic [ROOT_W-1:0] q;
        r = in_rem;
        q = in_root;
        for (int k = 0; k < DIGITS; k++)
        begin
            // bring down the next pair of radicand bits
            r     = {r[REM_W-3:0], in_rad[2*(FIRST_DIGIT-k)+1 -: 2]};
            trial = {1'b0, q, 2'b01};
            if (r >= trial)
            begin
                r = r - trial;
                q = {q[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                q = {q[ROOT_W-2:0], 1'b0};
            end
        end
        rem_next  = r;
        root_next = q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        side_reg <= in_side;
        rad_reg  <= in_rad;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign valid = valid_reg;
    assign side  = side_reg;
    assign rad   = rad_reg;
    assign rem   = rem_reg;
    assign root  = root_reg;

endmodule

// ===== sv/jdm_mix.sv =====
// joystick drive mixer, last stage: scales the magnitude and picks each motor's level,
// then holds the result register and its strobe; depends on jdm_pkg

module jdm_mix (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  jdm_pkg::mix_side_t         side,
    input  logic [jdm_pkg::ROOT_W-1:0] mag,
    output logic                       done,
    output jdm_pkg::drive_res_t        result
);
    import jdm_pkg::*;

    logic               done_reg;
    drive_res_t         res_reg;
    drive_res_t         res_next;
    logic [LEVEL_W-1:0] lvl_mag;

    function automatic logic [LEVEL_W-1:0] pick(
        input lvl_src_t           src,
        input logic [LEVEL_W-1:0] lx,
        input logic [LEVEL_W-1:0] ly,
        input logic [LEVEL_W-1:0] lm
    );
        logic [LEVEL_W-1:0] v;
        unique case (src)
            SRC_X:   v = lx;
            SRC_Y:   v = ly;
            SRC_MAG: v = lm;
            default: v = '0;
        endcase
        return v;
    endfunction

    assign lvl_mag = scale_level(mag);

    always_comb
    begin
        res_next.motor_a_dir = side.ctl.da;
        res_next.motor_b_dir = side.ctl.db;
        res_next.level_a     = pick(side.ctl.src_a, side.lvl_x, side.lvl_y, lvl_mag);
        res_next.level_b     = pick(side.ctl.src_b, side.lvl_x, side.lvl_y, lvl_mag);
        res_next.blocked     = side.ctl.blocked;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
